// File: rtl/quadrature_motor_speed_position_ctrl_defines.svh
// Assertion macros shared by the motor controller RTL.
// In synthesis builds every macro expands to nothing.
`ifndef QUADRATURE_MOTOR_SPEED_POSITION_CTRL_DEFINES_SVH
`define QUADRATURE_MOTOR_SPEED_POSITION_CTRL_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication: whenever ante holds, cons holds too.
`define QMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define QMC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

// The expression must never be true.
`define QMC_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("assertion failed: forbidden condition");

`else

`define QMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define QMC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`define QMC_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// File: rtl/qmc_pkg.sv
package qmc_pkg;

	// Field widths
	localparam int CPR_W       = 13;
	localparam int SCALE_W     = 16;
	localparam int DUTY_W      = 8;
	localparam int RPM_W       = 16;
	localparam int VALUE_W     = 16;
	localparam int MODE_W      = 2;
	localparam int REQ_W       = 2;
	localparam int CMD_W       = 8;
	localparam int GOAL_W      = CPR_W + VALUE_W;
	localparam int OUT_COUNT_W = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int OP_W        = 3;

	// Decoded item queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Request types on the input channel
	localparam logic [REQ_W-1:0] REQ_EDGE_A = 2'd0;
	localparam logic [REQ_W-1:0] REQ_EDGE_B = 2'd1;
	localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;
	localparam logic [REQ_W-1:0] REQ_CMD    = 2'd3;

	// Command bytes
	localparam logic [CMD_W-1:0] CMD_STOP     = 8'h45;
	localparam logic [CMD_W-1:0] CMD_SPEED    = 8'h53;
	localparam logic [CMD_W-1:0] CMD_POSITION = 8'h50;

	// Decoded operations
	localparam logic [OP_W-1:0] OP_INC   = 3'd0;
	localparam logic [OP_W-1:0] OP_DEC   = 3'd1;
	localparam logic [OP_W-1:0] OP_TICK  = 3'd2;
	localparam logic [OP_W-1:0] OP_STOP  = 3'd3;
	localparam logic [OP_W-1:0] OP_SPEED = 3'd4;
	localparam logic [OP_W-1:0] OP_POS   = 3'd5;
	localparam logic [OP_W-1:0] OP_NOP   = 3'd6;

	// Run modes
	localparam logic [MODE_W-1:0] RUN_STOPPED = 2'd0;
	localparam logic [MODE_W-1:0] RUN_SPEED   = 2'd1;
	localparam logic [MODE_W-1:0] RUN_POS     = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CPR        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RPM_SCALE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_STEP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_DUTY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_POS_DUTY   = 3'd4;

	// Configuration reset values
	localparam logic [CPR_W-1:0]   CPR_RST        = 13'd80;
	localparam logic [SCALE_W-1:0] RPM_SCALE_RST  = 16'd600;
	localparam logic [DUTY_W-1:0]  SPEED_STEP_RST = 8'd5;
	localparam logic [DUTY_W-1:0]  START_DUTY_RST = 8'd80;
	localparam logic [DUTY_W-1:0]  POS_DUTY_RST   = 8'd150;

	localparam logic [DUTY_W-1:0] DUTY_MAX = 8'hFF;
	localparam logic [RPM_W-1:0]  RPM_MAX  = 16'hFFFF;

	typedef struct packed {
		logic [CPR_W-1:0]   cpr;
		logic [SCALE_W-1:0] scale;
		logic [DUTY_W-1:0]  step;
		logic [DUTY_W-1:0]  start_duty;
		logic [DUTY_W-1:0]  pos_duty;
	} cfg_t;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [VALUE_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic [DUTY_W-1:0]             duty;
		logic                          fwd;
		logic [MODE_W-1:0]             mode;
		logic [RPM_W-1:0]              rpm;
		logic                          reached;
		logic signed [OUT_COUNT_W-1:0] count;
	} result_t;

endpackage

// File: rtl/qmc_front.sv
module qmc_front (
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [qmc_pkg::REQ_W-1:0]      req_type,
	input  logic                           chan_a,
	input  logic                           chan_b,
	input  logic [qmc_pkg::CMD_W-1:0]      cmd_mode,
	input  logic [qmc_pkg::VALUE_W-1:0]    cmd_value,
	input  logic                           q_full,
	output logic                           q_push,
	output qmc_pkg::item_t                 q_item
);

	// The input side stalls only while the queue has no free entry.
	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	// Classify the item into one operation for the back end.
	always_comb begin
		q_item.value = cmd_value;
		case (req_type)
			qmc_pkg::REQ_EDGE_A: begin
				q_item.op = (chan_a == chan_b) ? qmc_pkg::OP_INC : qmc_pkg::OP_DEC;
			end
			qmc_pkg::REQ_EDGE_B: begin
				q_item.op = (chan_a != chan_b) ? qmc_pkg::OP_INC : qmc_pkg::OP_DEC;
			end
			qmc_pkg::REQ_TICK: begin
				q_item.op = qmc_pkg::OP_TICK;
			end
			default: begin
				case (cmd_mode)
					qmc_pkg::CMD_STOP:     q_item.op = qmc_pkg::OP_STOP;
					qmc_pkg::CMD_SPEED:    q_item.op = qmc_pkg::OP_SPEED;
					qmc_pkg::CMD_POSITION: q_item.op = qmc_pkg::OP_POS;
					default:               q_item.op = qmc_pkg::OP_NOP;
				endcase
			end
		endcase
	end

endmodule

// File: rtl/qmc_queue.sv
`include "quadrature_motor_speed_position_ctrl_defines.svh"

module qmc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  qmc_pkg::item_t push_item,
	input  logic           pop,
	output qmc_pkg::item_t head,
	output logic           full,
	output logic           empty
);

	localparam int PTR_W = (qmc_pkg::QUEUE_DEPTH > 1) ? $clog2(qmc_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(qmc_pkg::QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(qmc_pkg::QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(qmc_pkg::QUEUE_DEPTH - 1);

	qmc_pkg::item_t   entry_q [qmc_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_FULL);
	assign empty = (cnt_q == '0);
	assign head  = entry_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// A full queue takes no transfer, an empty one gives none, and the count tracks pushes.
	`QMC_ASSERT_NEVER(a_no_push_full, clk, arst_n, push && full)
	`QMC_ASSERT_NEVER(a_no_pop_empty, clk, arst_n, pop && empty)
	`QMC_ASSERT_NXT(a_cnt_up, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + CNT_W'(1))

endmodule

// File: rtl/qmc_rpm.sv
module qmc_rpm #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [COUNT_WIDTH-1:0]         delta,
	input  logic [qmc_pkg::SCALE_W-1:0]    scale,
	input  logic [qmc_pkg::CPR_W-1:0]      cpr,
	output logic                           done,
	output logic [qmc_pkg::RPM_W-1:0]      rpm
);

	localparam int PW     = COUNT_WIDTH + qmc_pkg::SCALE_W;
	localparam int STEPS  = (qmc_pkg::SCALE_W > qmc_pkg::RPM_W) ? qmc_pkg::SCALE_W
		: qmc_pkg::RPM_W;
	localparam int STEP_W = $clog2(STEPS);
	localparam int CPR_W  = qmc_pkg::CPR_W;
	localparam int RPM_W  = qmc_pkg::RPM_W;

	localparam logic [2:0] R_IDLE = 3'd0;
	localparam logic [2:0] R_ABS  = 3'd1;
	localparam logic [2:0] R_MUL  = 3'd2;
	localparam logic [2:0] R_CHK  = 3'd3;
	localparam logic [2:0] R_DIV  = 3'd4;

	logic [2:0]                  state_q;
	logic [STEP_W-1:0]           step_q;
	logic                        done_q;
	logic [COUNT_WIDTH-1:0]      delta_q;
	logic [COUNT_WIDTH-1:0]      mag_q;
	logic [qmc_pkg::SCALE_W-1:0] mult_q;
	logic [PW-1:0]               acc_q;
	logic [CPR_W-1:0]            rem_q;
	logic [RPM_W-1:0]            low_q;
	logic [RPM_W-1:0]            rpm_q;

	logic [PW-1:0]      addend;
	logic [CPR_W:0]     trial;
	logic [CPR_W:0]     trial_diff;
	logic               trial_ge;
	logic               acc_zero;
	logic               acc_sat;

	// Shift-add multiply, most significant multiplier bit first.
	assign addend = mult_q[qmc_pkg::SCALE_W-1] ? {{qmc_pkg::SCALE_W{1'b0}}, mag_q} : '0;

	// The quotient fits the result width only when the upper product is below the divisor.
	assign acc_zero = (acc_q == '0);
	assign acc_sat  = (acc_q[PW-1:RPM_W] >= {{(COUNT_WIDTH-CPR_W){1'b0}}, cpr});

	// One restoring division step per cycle.
	assign trial      = {rem_q, low_q[RPM_W-1]};
	assign trial_diff = trial - {1'b0, cpr};
	assign trial_ge   = (trial >= {1'b0, cpr});

	assign done = done_q;
	assign rpm  = rpm_q;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				R_IDLE: begin
					if (start) begin
						state_q <= R_ABS;
					end
				end
				R_ABS: begin
					step_q  <= STEP_W'(qmc_pkg::SCALE_W - 1);
					state_q <= R_MUL;
				end
				R_MUL: begin
					if (step_q == '0) begin
						state_q <= R_CHK;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				R_CHK: begin
					if (acc_zero || acc_sat) begin
						done_q  <= 1'b1;
						state_q <= R_IDLE;
					end else begin
						step_q  <= STEP_W'(RPM_W - 1);
						state_q <= R_DIV;
					end
				end
				R_DIV: begin
					if (step_q == '0) begin
						done_q  <= 1'b1;
						state_q <= R_IDLE;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				default: begin
					state_q <= R_IDLE;
				end
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			R_IDLE: begin
				if (start) begin
					delta_q <= delta;
				end
			end
			R_ABS: begin
				mag_q  <= delta_q[COUNT_WIDTH-1] ? (~delta_q + COUNT_WIDTH'(1)) : delta_q;
				mult_q <= scale;
				acc_q  <= '0;
			end
			R_MUL: begin
				acc_q  <= {acc_q[PW-2:0], 1'b0} + addend;
				mult_q <= {mult_q[qmc_pkg::SCALE_W-2:0], 1'b0};
			end
			R_CHK: begin
				if (acc_zero) begin
					rpm_q <= '0;
				end else if (acc_sat) begin
					rpm_q <= qmc_pkg::RPM_MAX;
				end
				rem_q <= acc_q[RPM_W +: CPR_W];
				low_q <= acc_q[RPM_W-1:0];
			end
			R_DIV: begin
				rem_q <= trial_ge ? trial_diff[CPR_W-1:0] : trial[CPR_W-1:0];
				low_q <= {low_q[RPM_W-2:0], trial_ge};
				if (step_q == '0) begin
					rpm_q <= {low_q[RPM_W-2:0], trial_ge};
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// File: rtl/qmc_back.sv
`include "quadrature_motor_speed_position_ctrl_defines.svh"

module qmc_back #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  qmc_pkg::cfg_t                cfg,
	input  logic                         q_empty,
	input  qmc_pkg::item_t               q_head,
	output logic                         q_pop,
	output logic                         rpm_start,
	output logic [COUNT_WIDTH-1:0]       rpm_delta,
	input  logic                         rpm_done,
	input  logic [qmc_pkg::RPM_W-1:0]    rpm_value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output qmc_pkg::result_t             res
);

	localparam int WIDE_W = ((COUNT_WIDTH > qmc_pkg::OUT_COUNT_W) ? COUNT_WIDTH
		: qmc_pkg::OUT_COUNT_W) + 1;
	localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WAIT  = 2'd1;
	localparam logic [1:0] ST_CHECK = 2'd2;

	logic [1:0]                    state_q;
	logic [COUNT_WIDTH-1:0]        count_q;
	logic [COUNT_WIDTH-1:0]        last_q;
	logic [qmc_pkg::MODE_W-1:0]    mode_q;
	logic [qmc_pkg::VALUE_W-1:0]   target_q;
	logic [qmc_pkg::DUTY_W-1:0]    duty_q;
	logic [qmc_pkg::RPM_W-1:0]     rpm_q;
	logic [qmc_pkg::GOAL_W-1:0]    goal_q;
	logic                          done_q;
	logic                          fwd_q;
	logic                          out_valid_q;
	qmc_pkg::result_t              res_q;

	logic                          out_free;
	logic                          emit;
	logic                          reach;
	logic [WIDE_W-1:0]             cnt_ext;
	logic [WIDE_W-1:0]             goal_ext;
	logic [qmc_pkg::DUTY_W:0]      duty_sum;
	logic [qmc_pkg::DUTY_W-1:0]    duty_up;
	logic [qmc_pkg::DUTY_W-1:0]    duty_down;

	assign out_free  = !out_valid_q || !out_stall;
	assign emit      = (state_q == ST_CHECK) && out_free;
	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign rpm_start = q_pop && (q_head.op == qmc_pkg::OP_TICK)
		&& (mode_q == qmc_pkg::RUN_SPEED);
	assign rpm_delta = count_q - last_q;

	// Signed count against the goal, both widened to one common width.
	assign cnt_ext  = {{(WIDE_W-COUNT_WIDTH){count_q[COUNT_WIDTH-1]}}, count_q};
	assign goal_ext = {{(WIDE_W-qmc_pkg::GOAL_W){1'b0}}, goal_q};
	assign reach    = (mode_q == qmc_pkg::RUN_POS) && !done_q
		&& ($signed(cnt_ext) >= $signed(goal_ext));

	// Saturating duty steps.
	assign duty_sum  = {1'b0, duty_q} + {1'b0, cfg.step};
	assign duty_up   = duty_sum[qmc_pkg::DUTY_W] ? qmc_pkg::DUTY_MAX
		: duty_sum[qmc_pkg::DUTY_W-1:0];
	assign duty_down = (duty_q < cfg.step) ? '0 : duty_q - cfg.step;

	assign out_valid = out_valid_q;
	assign res       = res_q;

	// Controller state and execution of one item at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			last_q   <= '0;
			mode_q   <= qmc_pkg::RUN_STOPPED;
			target_q <= '0;
			duty_q   <= '0;
			rpm_q    <= '0;
			goal_q   <= '0;
			done_q   <= 1'b0;
			fwd_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= rpm_start ? ST_WAIT : ST_CHECK;
						case (q_head.op)
							qmc_pkg::OP_INC: begin
								count_q <= count_q + CNT_ONE;
							end
							qmc_pkg::OP_DEC: begin
								count_q <= count_q - CNT_ONE;
							end
							qmc_pkg::OP_TICK: begin
								if (mode_q == qmc_pkg::RUN_SPEED) begin
									last_q <= count_q;
								end
							end
							qmc_pkg::OP_STOP: begin
								mode_q <= qmc_pkg::RUN_STOPPED;
								fwd_q  <= 1'b0;
								duty_q <= '0;
							end
							qmc_pkg::OP_SPEED: begin
								mode_q   <= qmc_pkg::RUN_SPEED;
								target_q <= q_head.value;
								last_q   <= count_q;
								rpm_q    <= '0;
								fwd_q    <= (q_head.value != '0);
								duty_q   <= (q_head.value != '0) ? cfg.start_duty : '0;
							end
							qmc_pkg::OP_POS: begin
								mode_q   <= qmc_pkg::RUN_POS;
								target_q <= q_head.value;
								count_q  <= '0;
								goal_q   <= qmc_pkg::GOAL_W'(q_head.value)
									* qmc_pkg::GOAL_W'(cfg.cpr);
								done_q   <= (q_head.value == '0);
								fwd_q    <= (q_head.value != '0);
								duty_q   <= (q_head.value != '0) ? cfg.pos_duty : '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_WAIT: begin
					// Bang-bang step of the duty toward the target speed.
					if (rpm_done) begin
						rpm_q   <= rpm_value;
						state_q <= ST_CHECK;
						if (rpm_value < target_q) begin
							duty_q <= duty_up;
						end else if (rpm_value > target_q) begin
							duty_q <= duty_down;
						end
					end
				end
				ST_CHECK: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (reach) begin
							fwd_q  <= 1'b0;
							duty_q <= '0;
							done_q <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register: result fields, with the position check folded in
	always_ff @(posedge clk) begin
		if (emit) begin
			res_q.duty    <= reach ? '0 : duty_q;
			res_q.fwd     <= reach ? 1'b0 : fwd_q;
			res_q.mode    <= mode_q;
			res_q.rpm     <= rpm_q;
			res_q.reached <= reach || done_q;
			res_q.count   <= cnt_ext[qmc_pkg::OUT_COUNT_W-1:0];
		end
	end

	// The rate unit answers only while a tick waits, a finished move leaves the bridge off,
	// and a nonzero duty always comes with forward drive.
	`QMC_ASSERT_IMP(a_rpm_done_wait, clk, arst_n, rpm_done, state_q == ST_WAIT)
	`QMC_ASSERT_IMP(a_pos_off, clk, arst_n, (mode_q == qmc_pkg::RUN_POS) && done_q, {fwd_q, duty_q} == '0)
	`QMC_ASSERT_IMP(a_duty_fwd, clk, arst_n, duty_q != '0, fwd_q)

endmodule

// File: rtl/quadrature_motor_speed_position_ctrl.sv
// Quadrature encoder motor controller with stop, speed and position modes. Every input
// transfer (encoder edge, speed-sample tick or command) yields exactly one result transfer
// with the duty, bridge state, mode, last rpm, done flag and signed count after that item.
// A two-entry queue decouples the input from the execution unit, so items are taken while
// a result waits. The back end takes every item but a speed-mode tick from idle straight to
// the result check; such a tick waits for the rpm unit: 16 shift-add multiply and 16
// restoring divide steps, the divide skipped on a zero or saturated rpm. COUNT_WIDTH sets the
// wrapping quadrature counter width; the count port sign-extends or truncates it to 32 bits.
// The configuration port is always ready; writes to indexes beyond the register list are
// dropped, and configuration is to be written only while the block is idle.
module quadrature_motor_speed_position_ctrl #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [qmc_pkg::REQ_W-1:0]            req_type,
	input  logic                                 chan_a,
	input  logic                                 chan_b,
	input  logic [qmc_pkg::CMD_W-1:0]            cmd_mode,
	input  logic [qmc_pkg::VALUE_W-1:0]          cmd_value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [qmc_pkg::DUTY_W-1:0]           pwm_duty,
	output logic                                 drive_forward,
	output logic [qmc_pkg::MODE_W-1:0]           mode_now,
	output logic [qmc_pkg::RPM_W-1:0]            measured_rpm,
	output logic                                 position_reached,
	output logic signed [qmc_pkg::OUT_COUNT_W-1:0] position_count,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [qmc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [qmc_pkg::CFG_DATA_W-1:0]       cfg_data
);

	qmc_pkg::cfg_t            cfg_q;
	qmc_pkg::item_t           push_item;
	qmc_pkg::item_t           head_item;
	qmc_pkg::result_t         res;
	logic                     q_push;
	logic                     q_pop;
	logic                     q_full;
	logic                     q_empty;
	logic                     rpm_start;
	logic                     rpm_done;
	logic [COUNT_WIDTH-1:0]   rpm_delta;
	logic [qmc_pkg::RPM_W-1:0] rpm_value;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cpr        <= qmc_pkg::CPR_RST;
			cfg_q.scale      <= qmc_pkg::RPM_SCALE_RST;
			cfg_q.step       <= qmc_pkg::SPEED_STEP_RST;
			cfg_q.start_duty <= qmc_pkg::START_DUTY_RST;
			cfg_q.pos_duty   <= qmc_pkg::POS_DUTY_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				qmc_pkg::REG_CPR:        cfg_q.cpr        <= cfg_data[qmc_pkg::CPR_W-1:0];
				qmc_pkg::REG_RPM_SCALE:  cfg_q.scale      <= cfg_data[qmc_pkg::SCALE_W-1:0];
				qmc_pkg::REG_SPEED_STEP: cfg_q.step       <= cfg_data[qmc_pkg::DUTY_W-1:0];
				qmc_pkg::REG_START_DUTY: cfg_q.start_duty <= cfg_data[qmc_pkg::DUTY_W-1:0];
				qmc_pkg::REG_POS_DUTY:   cfg_q.pos_duty   <= cfg_data[qmc_pkg::DUTY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	qmc_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.chan_a    (chan_a),
		.chan_b    (chan_b),
		.cmd_mode  (cmd_mode),
		.cmd_value (cmd_value),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (push_item)
	);

	qmc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.pop       (q_pop),
		.head      (head_item),
		.full      (q_full),
		.empty     (q_empty)
	);

	qmc_rpm #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_rpm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rpm_start),
		.delta  (rpm_delta),
		.scale  (cfg_q.scale),
		.cpr    (cfg_q.cpr),
		.done   (rpm_done),
		.rpm    (rpm_value)
	);

	qmc_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_head    (head_item),
		.q_pop     (q_pop),
		.rpm_start (rpm_start),
		.rpm_delta (rpm_delta),
		.rpm_done  (rpm_done),
		.rpm_value (rpm_value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	assign pwm_duty         = res.duty;
	assign drive_forward    = res.fwd;
	assign mode_now         = res.mode;
	assign measured_rpm     = res.rpm;
	assign position_reached = res.reached;
	assign position_count   = res.count;

endmodule

// File: test/tb.sv
module tb;

	localparam int CYCLE_LIMIT     = 500000;
	localparam int SETTLE_CYCLES   = 50;
	localparam int HOLD_CYCLES     = 400;
	localparam int HOLD_AFTER      = 120;
	localparam int PHASES          = 6;
	localparam int ITEMS_PER_PHASE = 75;
	localparam int REPORT_LIMIT    = 10;

	// Index past the end of the register list; the block drops such writes.
	localparam logic [qmc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic [qmc_pkg::REQ_W-1:0]   req;
		logic                        a;
		logic                        b;
		logic [qmc_pkg::CMD_W-1:0]   cmd;
		logic [qmc_pkg::VALUE_W-1:0] value;
	} motor_item_t;

	// One row of the directed sequence: either a register write (index in reg_idx,
	// data in item.value) or an item, optionally with a hand-written expected status.
	typedef struct packed {
		logic                          wr_reg;
		logic [qmc_pkg::CFG_IDX_W-1:0] reg_idx;
		motor_item_t                   item;
		logic                          typed;
		qmc_pkg::result_t              want;
	} plan_row_t;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_ALTERNATE} stall_style_t;

	localparam plan_row_t PLAN [30] = '{
		// Encoder direction rules starting from reset.
		'{1'b0, qmc_pkg::REG_CPR, '{qmc_pkg::REQ_EDGE_A, 1'b0, 1'b0, 8'h00, 16'h0000}, 1'b1,
			'{8'd0, 1'b0, qmc_pkg::RUN_STOPPED, 16'd0, 1'b0, 32'sd1}},
		'{1'b0, qmc_pkg::REG_CPR, '{qmc_pkg::REQ_EDGE_A, 1'b1, 1'b0, 8'h00, 16'h0000}, 1'b1,
			'{8'd0, 1'b0, qmc_pkg::RUN_STOPPED, 16'd0, 1'b0, 32'sd0}},
		'{1'b0, qmc_pkg::REG_CPR, '{qmc_pkg::REQ_EDGE_B, 1'b1, 1'b0, 8'h00, 16'h0000}, 1'b1,
			'{8'd0, 1'b0, qmc_pkg::RUN_STOPPED, 16'd0, 1'b0, 32'sd1}},
		'{1'b0, qmc_pkg::REG_CPR, '{qmc_pkg::REQ_EDGE_B, 1'b1, 1'b1, 8'h00, 16'h0000}, 1'b1,
			'{8'd0, 1'b0, qmc_pkg::RUN_STOPPED, 16'd0, 1'b0, 32'sd0}},
		'{1'b0, qmc_pkg::REG_CPR, '{qmc_pkg::REQ_EDGE_B, 1'b0, 1'b0, 8'h00, 16'h0000}, 1'b1,
			'{8'd0, 1'b0, qmc_pkg::RUN_STOPPED, 16'd0, 1'b0, -32'sd1}},
		// A tick while stopped changes nothing.
		'{1'b0, qmc_pkg::REG_CPR,
			'{qmc_pkg::REQ_TICK, 1'b1, 1'b1, qmc_pkg::CMD_SPEED, 16'hFFFF}, 1'b1,
			'{8'd0, 1'b0, qmc_pkg::RUN_STOPPED, 16'd0, 1'b0, -32'sd1}},
		// Speed mode with a zero target keeps the bridge off.
		'{1'b0, qmc_pkg::REG_CPR,
			'{qmc_pkg::REQ_CMD, 1'b0, 1'b0, qmc_pkg::CMD_SPEED, 16'h0000}, 1'b1,
			'{8'd0, 1'b0, qmc_pkg::RUN_SPEED, 16'd0, 1'b0, -32'sd1}},
		'{1'b0, qmc_pkg::REG_CPR,
			'{qmc_pkg::REQ_CMD, 1'b0, 1'b0, qmc_pkg::CMD_SPEED, 16'hFFFF}, 1'b1,
			'{qmc_pkg::START_DUTY_RST, 1'b1, qmc_pkg::RUN_SPEED, 16'd0, 1'b0, -32'sd1}},
		'{1'b0, qmc_pkg::REG_CPR, '{qmc_pkg::REQ_EDGE_A, 1'b1, 1'b1, 8'h00, 16'h0000}, 1'b0, '0},
		'{1'b0, qmc_pkg::REG_CPR, '{qmc_pkg::REQ_TICK, 1'b0, 1'b0, 8'h00, 16'h0000}, 1'b0, '0},
		// Unknown command byte, then stop and the two position extremes.
		'{1'b0, qmc_pkg::REG_CPR, '{qmc_pkg::REQ_CMD, 1'b1, 1'b0, 8'hFF, 16'd1234}, 1'b0, '0},
		'{1'b0, qmc_pkg::REG_CPR,
			'{qmc_pkg::REQ_CMD, 1'b0, 1'b0, qmc_pkg::CMD_STOP, 16'h0000}, 1'b0, '0},
		'{1'b0, qmc_pkg::REG_CPR,
			'{qmc_pkg::REQ_CMD, 1'b0, 1'b0, qmc_pkg::CMD_POSITION, 16'h0000}, 1'b0, '0},
		'{1'b0, qmc_pkg::REG_CPR,
			'{qmc_pkg::REQ_CMD, 1'b0, 1'b0, qmc_pkg::CMD_POSITION, 16'hFFFF}, 1'b0, '0},
		'{1'b0, qmc_pkg::REG_CPR, '{qmc_pkg::REQ_EDGE_A, 1'b1, 1'b0, 8'h00, 16'h0000}, 1'b0, '0},
		// One count per revolution makes the position goal reachable in one edge.
		'{1'b1, qmc_pkg::REG_CPR, '{qmc_pkg::REQ_CMD, 1'b0, 1'b0, 8'h00, 16'd1}, 1'b0, '0},
		'{1'b1, qmc_pkg::REG_RPM_SCALE, '{qmc_pkg::REQ_CMD, 1'b0, 1'b0, 8'h00, 16'hFFFF}, 1'b0,
			'0},
		'{1'b0, qmc_pkg::REG_CPR,
			'{qmc_pkg::REQ_CMD, 1'b0, 1'b0, qmc_pkg::CMD_POSITION, 16'd1}, 1'b0, '0},
		'{1'b0, qmc_pkg::REG_CPR, '{qmc_pkg::REQ_EDGE_A, 1'b0, 1'b0, 8'h00, 16'h0000}, 1'b0, '0},
		// Rpm saturation drives the duty down.
		'{1'b0, qmc_pkg::REG_CPR,
			'{qmc_pkg::REQ_CMD, 1'b0, 1'b0, qmc_pkg::CMD_SPEED, 16'd100}, 1'b0, '0},
		'{1'b0, qmc_pkg::REG_CPR, '{qmc_pkg::REQ_EDGE_B, 1'b0, 1'b1, 8'h00, 16'h0000}, 1'b0, '0},
		'{1'b0, qmc_pkg::REG_CPR, '{qmc_pkg::REQ_EDGE_B, 1'b1, 1'b0, 8'h00, 16'h0000}, 1'b0, '0},
		'{1'b0, qmc_pkg::REG_CPR, '{qmc_pkg::REQ_TICK, 1'b0, 1'b0, 8'h00, 16'h0000}, 1'b0, '0},
		// Zero counts per revolution saturates any nonzero product.
		'{1'b1, qmc_pkg::REG_CPR, '{qmc_pkg::REQ_CMD, 1'b0, 1'b0, 8'h00, 16'd0}, 1'b0, '0},
		'{1'b0, qmc_pkg::REG_CPR, '{qmc_pkg::REQ_EDGE_A, 1'b0, 1'b0, 8'h00, 16'h0000}, 1'b0, '0},
		'{1'b0, qmc_pkg::REG_CPR, '{qmc_pkg::REQ_TICK, 1'b0, 1'b0, 8'h00, 16'h0000}, 1'b0, '0},
		'{1'b0, qmc_pkg::REG_CPR, '{qmc_pkg::REQ_TICK, 1'b0, 1'b0, 8'h00, 16'h0000}, 1'b0, '0},
		// A full step saturates the duty at the top and holds it there.
		'{1'b1, qmc_pkg::REG_SPEED_STEP, '{qmc_pkg::REQ_CMD, 1'b0, 1'b0, 8'h00, 16'd255}, 1'b0,
			'0},
		'{1'b0, qmc_pkg::REG_CPR, '{qmc_pkg::REQ_TICK, 1'b0, 1'b0, 8'h00, 16'h0000}, 1'b0, '0},
		'{1'b0, qmc_pkg::REG_CPR, '{qmc_pkg::REQ_TICK, 1'b0, 1'b0, 8'h00, 16'h0000}, 1'b0, '0}
	};

	logic                                   clk;
	logic                                   arst_n;
	logic                                   in_valid;
	logic                                   in_stall;
	logic [qmc_pkg::REQ_W-1:0]              req_type;
	logic                                   chan_a;
	logic                                   chan_b;
	logic [qmc_pkg::CMD_W-1:0]              cmd_mode;
	logic [qmc_pkg::VALUE_W-1:0]            cmd_value;
	logic                                   out_valid;
	logic                                   out_stall;
	logic [qmc_pkg::DUTY_W-1:0]             pwm_duty;
	logic                                   drive_forward;
	logic [qmc_pkg::MODE_W-1:0]             mode_now;
	logic [qmc_pkg::RPM_W-1:0]              measured_rpm;
	logic                                   position_reached;
	logic signed [qmc_pkg::OUT_COUNT_W-1:0] position_count;
	logic                                   cfg_valid;
	logic                                   cfg_ready;
	logic [qmc_pkg::CFG_IDX_W-1:0]          cfg_index;
	logic [qmc_pkg::CFG_DATA_W-1:0]         cfg_data;

	// Motor state and register copy tracked by the predictor.
	logic [31:0]                 enc_count;
	logic [31:0]                 tick_ref_count;
	logic [31:0]                 goal_count;
	logic [qmc_pkg::MODE_W-1:0]  motor_mode;
	logic [qmc_pkg::VALUE_W-1:0] target_val;
	logic [qmc_pkg::DUTY_W-1:0]  duty_now;
	logic [qmc_pkg::RPM_W-1:0]   rpm_now;
	logic                        done_now;
	logic                        fwd_now;
	logic [qmc_pkg::CPR_W-1:0]   cpr_cfg;
	logic [qmc_pkg::SCALE_W-1:0] scale_cfg;
	logic [qmc_pkg::DUTY_W-1:0]  step_cfg;
	logic [qmc_pkg::DUTY_W-1:0]  start_duty_cfg;
	logic [qmc_pkg::DUTY_W-1:0]  pos_duty_cfg;

	qmc_pkg::result_t status_due [$];
	int               fails        = 0;
	int               results_seen = 0;
	int               cycle_count  = 0;

	quadrature_motor_speed_position_ctrl DUT (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Apply one item to the tracked motor state and return the status it leaves.
	function automatic qmc_pkg::result_t advance_motor(input motor_item_t it);
		logic [31:0]     delta;
		logic [31:0]     mag;
		longint unsigned rate;
		if (it.req == qmc_pkg::REQ_EDGE_A) begin
			enc_count = (it.a == it.b) ? enc_count + 32'd1 : enc_count - 32'd1;
		end else if (it.req == qmc_pkg::REQ_EDGE_B) begin
			enc_count = (it.a != it.b) ? enc_count + 32'd1 : enc_count - 32'd1;
		end else if (it.req == qmc_pkg::REQ_TICK) begin
			if (motor_mode == qmc_pkg::RUN_SPEED) begin
				delta = enc_count - tick_ref_count;
				tick_ref_count = enc_count;
				mag = delta[31] ? 32'd0 - delta : delta;
				rate = 64'(mag) * 64'(scale_cfg);
				if (cpr_cfg == '0)
					rate = (rate == 64'd0) ? 64'd0 : 64'd65535;
				else
					rate = rate / 64'(cpr_cfg);
				rpm_now = (rate > 64'd65535) ? qmc_pkg::RPM_MAX : 16'(rate);
				// Bang-bang: one step toward the target, clamped to the duty range.
				if (rpm_now < target_val) begin
					if (duty_now != qmc_pkg::DUTY_MAX)
						duty_now = (9'(duty_now) + 9'(step_cfg) > 9'd255)
							? qmc_pkg::DUTY_MAX : duty_now + step_cfg;
				end else if (rpm_now > target_val) begin
					if (duty_now != '0)
						duty_now = (duty_now < step_cfg) ? 8'd0 : duty_now - step_cfg;
				end
			end
		end else begin
			case (it.cmd)
				qmc_pkg::CMD_STOP: begin
					motor_mode = qmc_pkg::RUN_STOPPED;
					fwd_now = 1'b0;
					duty_now = '0;
				end
				qmc_pkg::CMD_SPEED: begin
					motor_mode = qmc_pkg::RUN_SPEED;
					target_val = it.value;
					tick_ref_count = enc_count;
					rpm_now = '0;
					fwd_now = (it.value != '0);
					duty_now = (it.value != '0) ? start_duty_cfg : 8'd0;
				end
				qmc_pkg::CMD_POSITION: begin
					motor_mode = qmc_pkg::RUN_POS;
					target_val = it.value;
					enc_count = '0;
					goal_count = 32'(it.value) * 32'(cpr_cfg);
					// Zero revolutions is done before the motor moves.
					done_now = (it.value == '0);
					fwd_now = (it.value != '0);
					duty_now = (it.value != '0) ? pos_duty_cfg : 8'd0;
				end
				default: ;
			endcase
		end
		// Position mode stops once the count reaches the goal.
		if (motor_mode == qmc_pkg::RUN_POS && !done_now &&
				$signed(enc_count) >= $signed(goal_count)) begin
			fwd_now = 1'b0;
			duty_now = '0;
			done_now = 1'b1;
		end
		return '{duty_now, fwd_now, motor_mode, rpm_now, done_now, enc_count};
	endfunction

	// Random item: mostly encoder edges drifting forward, with ticks and commands mixed in.
	function automatic motor_item_t random_item();
		motor_item_t it;
		int          pick;
		logic        up;
		it.a = 1'($urandom);
		it.b = 1'($urandom);
		it.cmd = 8'($urandom);
		it.value = 16'($urandom);
		pick = $urandom_range(0, 99);
		up = ($urandom_range(0, 99) < 75);
		if (pick < 65) begin
			it.req = ($urandom_range(0, 1) != 0) ? qmc_pkg::REQ_EDGE_B : qmc_pkg::REQ_EDGE_A;
			// Channel A counts up when the levels match, channel B when they differ.
			if (it.req == qmc_pkg::REQ_EDGE_A)
				it.b = up ? it.a : !it.a;
			else
				it.b = up ? !it.a : it.a;
		end else if (pick < 80) begin
			it.req = qmc_pkg::REQ_TICK;
		end else if (pick < 94) begin
			it.req = qmc_pkg::REQ_CMD;
			pick = $urandom_range(0, 5);
			if (pick == 0) begin
				it.cmd = qmc_pkg::CMD_STOP;
			end else if (pick < 4) begin
				it.cmd = qmc_pkg::CMD_SPEED;
				if ($urandom_range(0, 3) != 0)
					it.value = 16'($urandom_range(0, 400));
			end else begin
				it.cmd = qmc_pkg::CMD_POSITION;
				if ($urandom_range(0, 7) != 0)
					it.value = 16'($urandom_range(0, 5));
			end
		end else begin
			// Raw command byte, almost always one the block ignores.
			it.req = qmc_pkg::REQ_CMD;
		end
		return it;
	endfunction

	// Offer one item and hold it until the transfer happens.
	task automatic send_item(input motor_item_t it, input logic typed,
			input qmc_pkg::result_t want);
		qmc_pkg::result_t model_out;
		in_valid <= 1'b1;
		req_type <= it.req;
		chan_a <= it.a;
		chan_b <= it.b;
		cmd_mode <= it.cmd;
		cmd_value <= it.value;
		do @(posedge clk); while (in_stall);
		model_out = advance_motor(it);
		status_due.push_back(typed ? want : model_out);
	endtask

	task automatic idle_cycles(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Stop offering, wait for every expected status, then let the back end settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (status_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [qmc_pkg::CFG_IDX_W-1:0] idx,
			input logic [qmc_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			qmc_pkg::REG_CPR:        cpr_cfg = data[qmc_pkg::CPR_W-1:0];
			qmc_pkg::REG_RPM_SCALE:  scale_cfg = data;
			qmc_pkg::REG_SPEED_STEP: step_cfg = data[qmc_pkg::DUTY_W-1:0];
			qmc_pkg::REG_START_DUTY: start_duty_cfg = data[qmc_pkg::DUTY_W-1:0];
			qmc_pkg::REG_POS_DUTY:   pos_duty_cfg = data[qmc_pkg::DUTY_W-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Phase 0 sets cpr, scale and step to 1 and the duties to 0, phase 1 cpr 4096 and
	// the rest at maximum; later phases are random, mostly with a small cpr to reach goals.
	task automatic load_phase_config(input int p);
		int cpr, scale, step, start_duty, pos_duty;
		if (p == 0) begin
			cpr = 1;
			scale = 1;
			step = 1;
			start_duty = 0;
			pos_duty = 0;
		end else if (p == 1) begin
			cpr = 4096;
			scale = 65535;
			step = 255;
			start_duty = 255;
			pos_duty = 255;
		end else begin
			cpr = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 12);
			scale = $urandom_range(1, 65535);
			step = $urandom_range(1, 255);
			start_duty = $urandom_range(0, 255);
			pos_duty = $urandom_range(0, 255);
		end
		write_reg(qmc_pkg::REG_CPR, 16'(cpr));
		write_reg(qmc_pkg::REG_RPM_SCALE, 16'(scale));
		write_reg(qmc_pkg::REG_SPEED_STEP, 16'(step));
		write_reg(qmc_pkg::REG_START_DUTY, 16'(start_duty));
		write_reg(qmc_pkg::REG_POS_DUTY, 16'(pos_duty));
		if (p == 2)
			write_reg(REG_UNUSED, 16'($urandom));
	endtask

	// Bursts of items; gaps are short, mixed with long ones, or absent depending on phase.
	task automatic run_phase(input int p);
		int sent, burst;
		sent = 0;
		while (sent < ITEMS_PER_PHASE) begin
			burst = $urandom_range(1, 16);
			while (burst > 0 && sent < ITEMS_PER_PHASE) begin
				send_item(random_item(), 1'b0, '0);
				sent++;
				burst--;
			end
			if (sent < ITEMS_PER_PHASE && p % 3 != 2) begin
				if (p % 3 == 1 && $urandom_range(0, 3) == 0)
					idle_cycles($urandom_range(20, 60));
				else
					idle_cycles($urandom_range(1, 4));
			end
		end
	endtask

	// Stimulus: reset, the directed sequence, then the random phases.
	initial begin
		in_valid <= 1'b0;
		req_type <= qmc_pkg::REQ_EDGE_A;
		chan_a <= 1'b0;
		chan_b <= 1'b0;
		cmd_mode <= '0;
		cmd_value <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		arst_n <= 1'b0;
		enc_count = '0;
		tick_ref_count = '0;
		goal_count = '0;
		motor_mode = qmc_pkg::RUN_STOPPED;
		target_val = '0;
		duty_now = '0;
		rpm_now = '0;
		done_now = 1'b0;
		fwd_now = 1'b0;
		cpr_cfg = qmc_pkg::CPR_RST;
		scale_cfg = qmc_pkg::RPM_SCALE_RST;
		step_cfg = qmc_pkg::SPEED_STEP_RST;
		start_duty_cfg = qmc_pkg::START_DUTY_RST;
		pos_duty_cfg = qmc_pkg::POS_DUTY_RST;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(PLAN); i++) begin
			if (PLAN[i].wr_reg) begin
				wait_idle();
				write_reg(PLAN[i].reg_idx, PLAN[i].item.value);
			end else begin
				send_item(PLAN[i].item, PLAN[i].typed, PLAN[i].want);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			load_phase_config(p);
			run_phase(p);
		end

		wait_idle();
		if (fails == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Receiver stall: a style picked at random and redrawn when its stretch runs out, plus one long hold-off.
	initial begin : receiver
		int           hold_left;
		int           left_in_style;
		bit           held;
		stall_style_t style;
		out_stall <= 1'b0;
		hold_left = 0;
		left_in_style = 0;
		held = 1'b0;
		style = STALL_NONE;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && results_seen >= HOLD_AFTER) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (left_in_style == 0) begin
				style = stall_style_t'($urandom_range(0, 3));
				left_in_style = 128;
			end
			left_in_style--;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (style)
					STALL_NONE:  out_stall <= 1'b0;
					STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
					default:     out_stall <= left_in_style[0];
				endcase
			end
		end
	end

	// Compare each status transfer with the oldest expected status.
	always @(posedge clk) begin : status_check
		qmc_pkg::result_t got;
		qmc_pkg::result_t want;
		logic             bad;
		if (arst_n && out_valid && !out_stall) begin
			got = '{pwm_duty, drive_forward, mode_now, measured_rpm, position_reached,
				position_count};
			results_seen <= results_seen + 1;
			if (status_due.size() == 0) begin
				fails++;
				if (fails <= REPORT_LIMIT)
					$display("extra status: duty %0d fwd %0d mode %0d rpm %0d done %0d count %0d",
						got.duty, got.fwd, got.mode, got.rpm, got.reached,
						$signed(got.count));
			end else begin
				want = status_due.pop_front();
				bad = (got.duty !== want.duty) || (got.fwd !== want.fwd) ||
					(got.mode !== want.mode) || (got.rpm !== want.rpm) ||
					(got.reached !== want.reached) || (got.count !== want.count);
				if (bad) begin
					fails++;
					if (fails <= REPORT_LIMIT) begin
						$display("status %0d exp/act: duty %0d/%0d fwd %0d/%0d mode %0d/%0d",
							results_seen, want.duty, got.duty, want.fwd, got.fwd,
							want.mode, got.mode);
						$display("  rpm %0d/%0d reached %0d/%0d count %0d/%0d",
							want.rpm, got.rpm, want.reached, got.reached,
							$signed(want.count), $signed(got.count));
					end
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/qmc_pkg.sv
rtl/qmc_front.sv
rtl/qmc_queue.sv
rtl/qmc_rpm.sv
rtl/qmc_back.sv
rtl/quadrature_motor_speed_position_ctrl.sv
test/tb.sv
